@@ hdl/ghlc_pkg.sv @@
// Package for the group hit level cache policy core.
// Beat types, key type, tag store scan codes and sequencer states.
// No dependencies.
package ghlc_pkg;

    localparam int TABLE_W        = 5;
    localparam int ROW_W          = 24;
    localparam int SLOT_W         = 10;
    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 2;
    localparam int STAMP_W        = 32;
    localparam int DEF_CAPACITY   = 1024;
    localparam int DEF_GROUP_SIZE = 26;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERFECT = 2'd2;

    localparam logic [CFG_W-1:0] RST_CAPACITY    = 11'd768;
    localparam logic [CFG_W-1:0] RST_FLUSH_COUNT = 11'd307;
    localparam logic [CFG_W-1:0] RST_MAX_PERFECT = 11'd768;

    typedef struct packed {
        logic [TABLE_W-1:0] table_number;
        logic [ROW_W-1:0]   row_number;
        logic               group_end;
    } t_in_beat;

    typedef struct packed {
        logic [TABLE_W-1:0] out_table;
        logic               probe_hit;
        logic [SLOT_W-1:0]  slot_index;
        logic               needs_fill;
        logic               last_result;
    } t_out_beat;

    typedef struct packed {
        logic [TABLE_W-1:0] table_number;
        logic [ROW_W-1:0]   row_number;
    } t_key;

    typedef enum logic [2:0] {
        SCAN_MATCH,
        SCAN_OLDEST_LVL,
        SCAN_OLDEST_ANY,
        SCAN_FREE,
        SCAN_COUNT_LVL
    } t_scan_op;

    typedef struct packed {
        logic     start;
        t_scan_op op;
        t_key     key;
    } t_scan_req;

    typedef struct packed {
        logic done;
        logic found;
    } t_scan_rsp;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_READY,
        ST_PROBE,
        ST_KEY,
        ST_LOOKUP,
        ST_FLUSH,
        ST_FLUSH_WAIT,
        ST_CHECK,
        ST_VICT,
        ST_VICT_WAIT,
        ST_ANY_WAIT,
        ST_FREE_WAIT,
        ST_OUT,
        ST_PERF_WAIT
    } t_state;

endpackage

@@ hdl/ghlc_scan.sv @@
// Tag store memory and its scan unit: one entry read per cycle, one compare per entry.
// Depends on ghlc_pkg.
module ghlc_scan #(
    parameter int CAPACITY = ghlc_pkg::DEF_CAPACITY,
    parameter int LW       = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ghlc_pkg::t_scan_req           i_req,
    input  logic [LW-1:0]                 i_level,
    input  logic [ghlc_pkg::STAMP_W-1:0]  i_next_stamp,
    input  logic                          i_wr_en,
    input  logic [$clog2(CAPACITY)-1:0]   i_wr_addr,
    input  logic                          i_wr_valid,
    input  ghlc_pkg::t_key                i_wr_key,
    input  logic [LW-1:0]                 i_wr_level,
    input  logic [ghlc_pkg::STAMP_W-1:0]  i_wr_stamp,
    output ghlc_pkg::t_scan_rsp           o_rsp,
    output logic [$clog2(CAPACITY)-1:0]   o_idx,
    output logic [LW-1:0]                 o_level,
    output logic [$clog2(CAPACITY):0]     o_count
);
    import ghlc_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic               m_valid [CAPACITY];
    t_key               m_key   [CAPACITY];
    logic [LW-1:0]      m_level [CAPACITY];
    logic [STAMP_W-1:0] m_stamp [CAPACITY];

    logic               r_rd_valid;
    t_key               r_rd_key;
    logic [LW-1:0]      r_rd_level;
    logic [STAMP_W-1:0] r_rd_stamp;

    logic               r_busy, r_done, r_rvld, r_found;
    logic [AW:0]        r_cnt, r_count;
    logic [AW-1:0]      r_ridx, r_idx;
    t_scan_op           r_op;
    t_key               r_key;
    logic [LW-1:0]      r_lvl, r_best_level;
    logic [STAMP_W-1:0] r_best_age;

    logic [STAMP_W-1:0] w_age;
    logic               w_take, w_cnt_inc;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            m_valid[i_wr_addr] <= i_wr_valid;
            m_key[i_wr_addr]   <= i_wr_key;
            m_level[i_wr_addr] <= i_wr_level;
            m_stamp[i_wr_addr] <= i_wr_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_valid <= m_valid[r_cnt[AW-1:0]];
        r_rd_key   <= m_key[r_cnt[AW-1:0]];
        r_rd_level <= m_level[r_cnt[AW-1:0]];
        r_rd_stamp <= m_stamp[r_cnt[AW-1:0]];
    end

    assign w_age = i_next_stamp - r_rd_stamp;

    always_comb begin
        w_take    = 1'b0;
        w_cnt_inc = 1'b0;
        case (r_op)
            SCAN_MATCH:      w_take = r_rd_valid && !r_found && (r_rd_key == r_key);
            SCAN_OLDEST_LVL: w_take = r_rd_valid && (r_rd_level == r_lvl)
                                      && (!r_found || w_age > r_best_age);
            SCAN_OLDEST_ANY: w_take = r_rd_valid && (!r_found || w_age > r_best_age);
            SCAN_FREE:       w_take = !r_rd_valid && !r_found;
            SCAN_COUNT_LVL:  w_cnt_inc = r_rd_valid && (r_rd_level == r_lvl);
            default:         w_take = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_rvld  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_rvld  <= 1'b0;
                r_found <= 1'b0;
                r_count <= '0;
                r_op    <= i_req.op;
                r_key   <= i_req.key;
                r_lvl   <= i_level;
            end else if (r_busy) begin
                if (r_cnt < (AW+1)'(CAPACITY)) begin
                    r_cnt  <= r_cnt + 1'b1;
                    r_rvld <= 1'b1;
                    r_ridx <= r_cnt[AW-1:0];
                end else begin
                    r_rvld <= 1'b0;
                end
                if (r_rvld) begin
                    if (w_take) begin
                        r_found      <= 1'b1;
                        r_idx        <= r_ridx;
                        r_best_age   <= w_age;
                        r_best_level <= r_rd_level;
                    end
                    if (w_cnt_inc) r_count <= r_count + 1'b1;
                    if (r_ridx == AW'(CAPACITY - 1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        r_rvld <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.found = r_found;
    assign o_idx       = r_idx;
    assign o_level     = r_best_level;
    assign o_count     = r_count;

endmodule

@@ hdl/group_hit_level_cache_policy_core.sv @@
// Top level of the group hit level cache policy core: sequencer, group buffer, config.
// Depends on ghlc_pkg and ghlc_scan.
//
//  channel  dir  handshake            payload
//  in       in   i_in_valid/o_in_stall   i_in_beat  (t_in_beat)
//  out      out  o_out_valid/i_out_stall o_out_beat (t_out_beat)
//  cfg      in   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Every tag store pass runs over all CAPACITY entries through one read port and one compare.
// A key beat costs one probe pass; each key of a closed group costs a lookup pass, a free
// slot pass on a miss, one pass per flushed entry plus one if the top level empties, up to
// GROUP_SIZE+1 victim level passes and one any-level pass. A perfect group adds a count pass.
// After reset a clearing pass writes every tag store entry invalid before the first beat is taken.
// The in and cfg channels stall while a key or a group is worked; a stalled result holds.
module group_hit_level_cache_policy_core #(
    parameter int CAPACITY   = ghlc_pkg::DEF_CAPACITY,
    parameter int GROUP_SIZE = ghlc_pkg::DEF_GROUP_SIZE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  ghlc_pkg::t_in_beat              i_in_beat,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ghlc_pkg::t_out_beat             o_out_beat,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ghlc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ghlc_pkg::CFG_W-1:0]      i_cfg_data
);
    import ghlc_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(GROUP_SIZE + 1);
    localparam int KW = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_cnt, n_cnt;
    logic [CFG_W-1:0]   r_cap, r_flush, r_maxp;
    logic [CFG_W-1:0]   r_perfect, n_perfect, r_fk, n_fk;
    logic [STAMP_W-1:0] r_next_stamp, n_next_stamp;
    logic [LW-1:0]      r_lowest, n_lowest, r_hit_total, n_hit_total;
    logic [LW-1:0]      r_glen, n_glen, r_k, n_k, r_L, n_L, r_tries, n_tries;
    logic [GROUP_SIZE-1:0] r_hits, n_hits;
    logic [AW:0]        r_vcount, n_vcount;
    logic               r_end;
    t_out_beat          r_out, n_out;
    t_key               r_rows [GROUP_SIZE];

    t_scan_req          w_req;
    logic [LW-1:0]      w_req_lvl, w_Lnext;
    t_scan_rsp          w_rsp;
    logic [AW-1:0]      w_idx;
    logic [LW-1:0]      w_level;
    logic [AW:0]        w_count, w_cap;
    t_key               w_key;
    logic               w_wr_en, w_wr_valid;
    logic [AW-1:0]      w_wr_addr;
    logic               w_accept, w_last;

    ghlc_scan #(.CAPACITY(CAPACITY), .LW(LW)) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (w_req),
        .i_level      (w_req_lvl),
        .i_next_stamp (r_next_stamp),
        .i_wr_en      (w_wr_en),
        .i_wr_addr    (w_wr_addr),
        .i_wr_valid   (w_wr_valid),
        .i_wr_key     (w_key),
        .i_wr_level   (r_hit_total),
        .i_wr_stamp   (r_next_stamp),
        .o_rsp        (w_rsp),
        .o_idx        (w_idx),
        .o_level      (w_level),
        .o_count      (w_count)
    );

    assign o_cfg_ready = (r_state == ST_READY);
    assign o_in_stall  = (r_state != ST_READY);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_out_beat  = r_out;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_key       = r_rows[r_k[KW-1:0]];
    assign w_last      = (r_k + LW'(1) == r_glen);
    assign w_Lnext     = (r_L == LW'(GROUP_SIZE)) ? LW'(1) : r_L + LW'(1);

    always_comb begin
        if (r_cap == '0)                         w_cap = (AW+1)'(1);
        else if (32'(r_cap) > 32'(CAPACITY))     w_cap = (AW+1)'(CAPACITY);
        else                                     w_cap = (AW+1)'(r_cap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= RST_CAPACITY;
            r_flush <= RST_FLUSH_COUNT;
            r_maxp  <= RST_MAX_PERFECT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CAPACITY:    r_cap   <= i_cfg_data;
                CFG_FLUSH_COUNT: r_flush <= i_cfg_data;
                CFG_MAX_PERFECT: r_maxp  <= i_cfg_data;
                default:         r_cap   <= r_cap;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rows[r_glen[KW-1:0]] <= '{table_number: i_in_beat.table_number,
                                         row_number:   i_in_beat.row_number};
            r_end <= i_in_beat.group_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_cnt        <= '0;
            r_perfect    <= '0;
            r_next_stamp <= '0;
            r_lowest     <= '0;
            r_hit_total  <= '0;
            r_glen       <= '0;
            r_hits       <= '0;
            r_vcount     <= '0;
            r_k          <= '0;
            r_fk         <= '0;
            r_L          <= '0;
            r_tries      <= '0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_perfect    <= n_perfect;
            r_next_stamp <= n_next_stamp;
            r_lowest     <= n_lowest;
            r_hit_total  <= n_hit_total;
            r_glen       <= n_glen;
            r_hits       <= n_hits;
            r_vcount     <= n_vcount;
            r_k          <= n_k;
            r_fk         <= n_fk;
            r_L          <= n_L;
            r_tries      <= n_tries;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_perfect    = r_perfect;
        n_next_stamp = r_next_stamp;
        n_lowest     = r_lowest;
        n_hit_total  = r_hit_total;
        n_glen       = r_glen;
        n_hits       = r_hits;
        n_vcount     = r_vcount;
        n_k          = r_k;
        n_fk         = r_fk;
        n_L          = r_L;
        n_tries      = r_tries;
        n_out        = r_out;
        w_req        = '{start: 1'b0, op: SCAN_MATCH, key: w_key};
        w_req_lvl    = LW'(GROUP_SIZE);
        w_wr_en      = 1'b0;
        w_wr_valid   = 1'b0;
        w_wr_addr    = w_idx;

        case (r_state)
            ST_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_cnt;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == AW'(CAPACITY - 1)) n_state = ST_READY;
            end
            ST_READY: begin
                if (w_accept) begin
                    w_req.start = 1'b1;
                    w_req.key   = '{table_number: i_in_beat.table_number,
                                    row_number:   i_in_beat.row_number};
                    n_state     = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (w_rsp.done) begin
                    n_hits[r_glen[KW-1:0]] = w_rsp.found;
                    n_hit_total = r_hit_total + LW'(w_rsp.found);
                    n_glen      = r_glen + LW'(1);
                    n_k         = '0;
                    if (r_end || (r_glen + LW'(1) == LW'(GROUP_SIZE))) n_state = ST_KEY;
                    else                                               n_state = ST_READY;
                end
            end
            ST_KEY: begin
                w_req.start = 1'b1;
                n_state     = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (w_rsp.done) begin
                    if (w_rsp.found) begin
                        if (w_level < r_hit_total) begin
                            w_wr_en      = 1'b1;
                            w_wr_valid   = 1'b1;
                            n_next_stamp = r_next_stamp + 1'b1;
                        end
                        n_out = '{out_table:   w_key.table_number,
                                  probe_hit:   r_hits[r_k[KW-1:0]],
                                  slot_index:  SLOT_W'(w_idx),
                                  needs_fill:  1'b0,
                                  last_result: w_last};
                        n_state = ST_OUT;
                    end else if (r_perfect >= r_maxp) begin
                        n_fk    = '0;
                        n_state = ST_FLUSH;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_FLUSH: begin
                if (r_fk < r_flush) begin
                    w_req.start = 1'b1;
                    w_req.op    = SCAN_OLDEST_LVL;
                    n_state     = ST_FLUSH_WAIT;
                end else begin
                    n_perfect = (r_perfect > r_flush) ? r_perfect - r_flush : '0;
                    n_state   = ST_CHECK;
                end
            end
            ST_FLUSH_WAIT: begin
                if (w_rsp.done) begin
                    if (w_rsp.found) begin
                        w_wr_en  = 1'b1;
                        n_vcount = r_vcount - 1'b1;
                        n_fk     = r_fk + 1'b1;
                    end else begin
                        n_fk = r_flush;
                    end
                    n_state = ST_FLUSH;
                end
            end
            ST_CHECK: begin
                if (r_vcount >= w_cap) begin
                    n_L     = (r_lowest > LW'(GROUP_SIZE)) ? LW'(1) : r_lowest;
                    n_tries = '0;
                    n_state = ST_VICT;
                end else begin
                    w_req.start = 1'b1;
                    w_req.op    = SCAN_FREE;
                    n_state     = ST_FREE_WAIT;
                end
            end
            ST_VICT: begin
                w_req.start = 1'b1;
                w_req.op    = SCAN_OLDEST_LVL;
                w_req_lvl   = r_L;
                n_state     = ST_VICT_WAIT;
            end
            ST_VICT_WAIT: begin
                if (w_rsp.done) begin
                    if (w_rsp.found) begin
                        n_lowest    = r_L;
                        w_wr_en     = 1'b1;
                        n_vcount    = r_vcount - 1'b1;
                        w_req.start = 1'b1;
                        w_req.op    = SCAN_FREE;
                        n_state     = ST_FREE_WAIT;
                    end else begin
                        n_L     = w_Lnext;
                        n_tries = r_tries + LW'(1);
                        if (r_tries == LW'(GROUP_SIZE)) begin
                            n_lowest    = w_Lnext;
                            w_req.start = 1'b1;
                            w_req.op    = SCAN_OLDEST_ANY;
                            n_state     = ST_ANY_WAIT;
                        end else begin
                            n_state = ST_VICT;
                        end
                    end
                end
            end
            ST_ANY_WAIT: begin
                if (w_rsp.done) begin
                    if (w_rsp.found) begin
                        w_wr_en  = 1'b1;
                        n_vcount = r_vcount - 1'b1;
                    end
                    w_req.start = 1'b1;
                    w_req.op    = SCAN_FREE;
                    n_state     = ST_FREE_WAIT;
                end
            end
            ST_FREE_WAIT: begin
                if (w_rsp.done) begin
                    w_wr_en      = 1'b1;
                    w_wr_valid   = 1'b1;
                    w_wr_addr    = w_rsp.found ? w_idx : '0;
                    n_next_stamp = r_next_stamp + 1'b1;
                    if (w_rsp.found) n_vcount = r_vcount + 1'b1;
                    if (r_hit_total < r_lowest) n_lowest = r_hit_total;
                    n_out = '{out_table:   w_key.table_number,
                              probe_hit:   r_hits[r_k[KW-1:0]],
                              slot_index:  SLOT_W'(w_wr_addr),
                              needs_fill:  1'b1,
                              last_result: w_last};
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_k = r_k + LW'(1);
                    if (!w_last) begin
                        n_state = ST_KEY;
                    end else if (r_hit_total == LW'(GROUP_SIZE)) begin
                        w_req.start = 1'b1;
                        w_req.op    = SCAN_COUNT_LVL;
                        n_state     = ST_PERF_WAIT;
                    end else begin
                        n_glen      = '0;
                        n_hit_total = '0;
                        n_hits      = '0;
                        n_state     = ST_READY;
                    end
                end
            end
            ST_PERF_WAIT: begin
                if (w_rsp.done) begin
                    if (32'(w_count) > 32'(2 ** CFG_W - 1)) n_perfect = '1;
                    else                                     n_perfect = CFG_W'(w_count);
                    n_glen      = '0;
                    n_hit_total = '0;
                    n_hits      = '0;
                    n_state     = ST_READY;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

endmodule
